/* rtl/core/per_key_send_throttle_assert.svh */
// ----------------------------------------------------------------------------
// per_key_send_throttle assertion macros
// Concurrent assertion shorthands used by the throttle engine.
// ----------------------------------------------------------------------------
`ifndef PER_KEY_SEND_THROTTLE_ASSERT_SVH
`define PER_KEY_SEND_THROTTLE_ASSERT_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define PKST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("per_key_send_throttle: assertion failed");
// condition must never be true outside reset
`define PKST_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("per_key_send_throttle: forbidden condition seen");
`else
`define PKST_ASSERT(lbl, clk, rst_n, prop)
`define PKST_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/core/pkst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkst_pkg
// Shared types and constants of the per-key send throttle.
// ----------------------------------------------------------------------------
package pkst_pkg;

    localparam int unsigned KEY_W           = 32;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned TABLE_SLOTS_DEF = 32;
    localparam logic [TIME_W-1:0] HOLD_RESET = TIME_W'(500);

    // input data bus: key in the low bits, timestamp above
    localparam int unsigned IN_DATA_W  = KEY_W + TIME_W;
    // result bus: pass, recorded, padded to one byte
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - 2;

    // one queued item
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [KEY_W-1:0]  key;
    } t_item;

    // one decision
    typedef struct packed {
        logic recorded;
        logic pass;
    } t_result;

    // back-end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_eng_state;

endpackage

/* rtl/core/pkst_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkst_front
// Input side: takes stream transactions into a two-entry queue so the
// lookup engine and the upstream source stall independently.
// ----------------------------------------------------------------------------
module pkst_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  pkst_pkg::t_item i_item,
    output logic           o_vld,
    input  logic           i_rdy,
    output pkst_pkg::t_item o_item
);
    import pkst_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = 1;
    localparam int unsigned CNT_W       = 2;

    t_item             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              push, pop;

    // handshake decode
    assign o_rdy  = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_vld  = (r_count != '0);
    assign push   = i_vld && o_rdy;
    assign pop    = o_vld && i_rdy;
    assign o_item = r_slot[r_rd_ptr];

    // pointer and occupancy update
    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/core/pkst_engine.sv */
`timescale 1ns / 1ps
`include "per_key_send_throttle_assert.svh"
// ----------------------------------------------------------------------------
// pkst_engine
// Back end: walks the key table one entry per cycle, decides pass or
// suppress, refreshes or appends the entry and holds the result.
// ----------------------------------------------------------------------------
module pkst_engine #(
    parameter int unsigned TABLE_SLOTS = pkst_pkg::TABLE_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pkst_pkg::TIME_W-1:0] i_cfg_wdata,
    input  logic                       i_q_vld,
    output logic                       o_q_rdy,
    input  pkst_pkg::t_item            i_q_item,
    output logic                       o_res_vld,
    input  logic                       i_res_rdy,
    output pkst_pkg::t_result          o_res
);
    import pkst_pkg::*;

    localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);

    t_eng_state         r_state, n_state;
    t_item              r_item;
    logic [TIME_W-1:0]  r_hold;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [CNT_W-1:0]   r_idx;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_chk_idx;
    t_item              r_rd_data;
    logic               r_out_vld;
    t_result            r_res, n_res;

    // key table: key and last pass time per entry
    t_item              r_table [TABLE_SLOTS];

    logic               key_hit;
    logic               scan_done;
    logic               table_full;
    logic               time_ok;
    logic               issue;
    logic [TIME_W-1:0]  elapsed;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_addr;
    logic               take;
    logic               decide;

    // compare path on the registered table read
    assign elapsed    = r_item.now_ms - r_rd_data.now_ms;
    assign time_ok    = (elapsed >= r_hold);
    assign key_hit    = (r_state == S_SCAN) && r_rd_vld && (r_rd_data.key == r_item.key);
    assign scan_done  = (r_state == S_SCAN) && !r_rd_vld && (r_idx == r_fill);
    assign table_full = (r_fill == CNT_W'(TABLE_SLOTS));
    assign issue      = (r_state == S_SCAN) && !key_hit && (r_idx < r_fill);
    assign take       = i_q_vld && o_q_rdy;
    assign decide     = key_hit || scan_done;

    assign o_res_vld  = r_out_vld;
    assign o_res      = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_vld) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (decide) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: table write, result and fill update
    always_comb begin
        o_q_rdy  = 1'b0;
        mem_we   = 1'b0;
        mem_addr = r_chk_idx;
        n_res    = r_res;
        n_fill   = r_fill;
        case (r_state)
            S_IDLE: begin
                o_q_rdy = 1'b1;
            end
            S_SCAN: begin
                if (key_hit) begin
                    // known key: refresh time only when it passes
                    mem_we         = time_ok;
                    mem_addr       = r_chk_idx;
                    n_res.pass     = time_ok;
                    n_res.recorded = 1'b1;
                end else if (scan_done) begin
                    // unknown key: append when a slot is free
                    mem_we         = !table_full;
                    mem_addr       = r_fill[IDX_W-1:0];
                    n_res.pass     = 1'b1;
                    n_res.recorded = !table_full;
                    if (!table_full) begin
                        n_fill = r_fill + CNT_W'(1);
                    end
                end
            end
            S_RESP: begin
                o_q_rdy = 1'b0;
            end
            default: o_q_rdy = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hold    <= HOLD_RESET;
            r_fill    <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_rd_vld <= issue;
            if (i_cfg_we) begin
                r_hold <= i_cfg_wdata;
            end
            if (take) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (r_state == S_SCAN && decide) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_res_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_q_item;
        end
        if (issue) begin
            r_chk_idx <= r_idx[IDX_W-1:0];
        end
        if (decide) begin
            r_res <= n_res;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_addr] <= r_item;
        end
        if (issue) begin
            r_rd_data <= r_table[r_idx[IDX_W-1:0]];
        end
    end

    // checks
    `PKST_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= CNT_W'(TABLE_SLOTS))
    `PKST_ASSERT(a_out_in_resp, i_clk, i_rst_n, r_out_vld == (r_state == S_RESP))
    `PKST_ASSERT(a_fill_step, i_clk, i_rst_n, ($past(i_rst_n) && (r_fill != $past(r_fill))) |-> (r_fill == $past(r_fill) + CNT_W'(1)))
    `PKST_ASSERT_NEVER(a_read_outside_scan, i_clk, i_rst_n, r_rd_vld && (r_state == S_IDLE))

endmodule

/* rtl/core/per_key_send_throttle.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_send_throttle
// Per-key rate limiter with a key table, a front queue and a lookup engine.
// ----------------------------------------------------------------------------
// Each input transaction carries a key and a millisecond timestamp and yields
// one result: pass and recorded. A key found in the table passes only when
// the wrapping time since its last pass is at least hold_interval_ms (reset
// 500), and a pass refreshes its time; an unknown key always passes and is
// appended while a slot is free. The engine reads the table one entry per
// cycle through a single registered memory port, so the time an item takes
// grows with the table fill and is shorter when the key is found early. A
// two-entry input queue keeps taking transactions while the engine works or
// a result waits. Write the hold interval only while the block is idle.
// Table entries are never removed.
// ----------------------------------------------------------------------------
module per_key_send_throttle #(
    parameter int unsigned TABLE_SLOTS = pkst_pkg::TABLE_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // hold interval register
    input  logic                            i_cfg_we,
    input  logic [pkst_pkg::TIME_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pkst_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // key[31:0], now_ms[63:32]
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pkst_pkg::OUT_DATA_W-1:0] m_axis_tdata    // pass[0], recorded[1], zero[7:2]
);
    import pkst_pkg::*;

    t_item   in_item;
    t_item   q_item;
    logic    q_vld;
    logic    q_rdy;
    t_result res;

    // unpack input transaction
    assign in_item.key    = s_axis_tdata[KEY_W-1:0];
    assign in_item.now_ms = s_axis_tdata[KEY_W +: TIME_W];

    // front queue
    pkst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_item  (in_item),
        .o_vld   (q_vld),
        .i_rdy   (q_rdy),
        .o_item  (q_item)
    );

    // lookup engine
    pkst_engine #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_vld     (q_vld),
        .o_q_rdy     (q_rdy),
        .i_q_item    (q_item),
        .o_res_vld   (m_axis_tvalid),
        .i_res_rdy   (m_axis_tready),
        .o_res       (res)
    );

    // pack result transaction
    assign m_axis_tdata = {OUT_PAD_W'(0), res.recorded, res.pass};

endmodule
